FILE: rtl/core/hhdt_pkg.sv
`default_nettype none
package hhdt_pkg;

  localparam int unsigned SLOTS   = 26;
  localparam int unsigned SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

  localparam int unsigned TIME_W = 40;
  localparam int unsigned QTY_W  = 48;
  localparam int unsigned SEC_W  = 20;
  localparam int unsigned PCT_W  = 24;
  localparam int unsigned ENTRY_W = TIME_W + 2 * QTY_W;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SECONDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_AGE     = 3'd4;

  localparam logic [TIME_W-1:0] MIN_VALID_TIME_RST = 40'd1609459200;
  localparam logic [SEC_W-1:0]  STEP_SECONDS_RST   = 20'd3600;
  localparam logic [SEC_W-1:0]  WINDOW_LOW_RST     = 20'd82800;
  localparam logic [SEC_W-1:0]  WINDOW_HIGH_RST    = 20'd90000;
  localparam logic [SEC_W-1:0]  TARGET_AGE_RST     = 20'd86400;

  localparam logic [PCT_W-1:0] PCT_POS_MAX = 24'h7FFFFF;
  localparam logic [PCT_W-1:0] PCT_NEG_MIN = 24'h800000;

endpackage
`default_nettype wire

FILE: rtl/core/hourly_history_day_trend.sv
// Channel  | Dir | Handshake                  | Payload
// s_axis   | in  | s_axis_tvalid/tready       | tdata: now, price, rate
// m_axis   | out | m_axis_tvalid/tready       | tdata: price, rate, pchg, rchg; tuser: flags
// cfg      | in  | cfg_valid/cfg_ready        | cfg_index, cfg_data
// One item at a time. A rejected item or one with the clock not set goes straight to
// publish. Otherwise: push, then a scan of every stored entry (memory read, then
// compare), a check, then two 64-step restoring divisions on one shared divider,
// and publish.
// Reset clears the counters and the published record; the snapshot memory is not cleared.
// A result waiting on m_axis does not block the next input item.
`default_nettype none
module hourly_history_day_trend import hhdt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [39:0] now_seconds, [87:40] asset_price, [135:88] currency_rate
  input  wire logic [135:0]          s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [47:0] price_now, [95:48] rate_now, [119:96] price_change_pct,
  // [143:120] rate_change_pct
  output logic [143:0]               m_axis_tdata_o,
  // [0] data_valid, [1] baseline_found
  output logic [1:0]                 m_axis_tuser_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [TIME_W-1:0]     cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EV   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DSET = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DEND = 3'd6;
  localparam logic [2:0] ST_PUB  = 3'd7;

  localparam logic [SLOT_AW:0] SLOTS_X = (SLOT_AW + 1)'(SLOTS);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  logic [2:0] state_q;

  logic [TIME_W-1:0] min_time_q;
  logic [SEC_W-1:0]  step_q, wlow_q, whigh_q, target_q;

  logic [ENTRY_W-1:0] mem [SLOTS];
  logic [ENTRY_W-1:0] rdata_q;

  logic [CNT_W-1:0]   count_q, idx_q;
  logic [SLOT_AW-1:0] head_q;
  logic [TIME_W-1:0]  last_time_q;

  logic [TIME_W-1:0] now_q;
  logic [QTY_W-1:0]  price_q, rate_q;

  logic              found_q;
  logic [TIME_W-1:0] best_dist_q;
  logic [QTY_W-1:0]  bprice_q, brate_q;

  logic              divsel_q, neg_q;
  logic [63:0]       num_q;
  logic [QTY_W:0]    rem_q;
  logic [5:0]        dcnt_q;
  logic [PCT_W-1:0]  pchg_q;

  logic              pub_valid_q, pub_trend_q;
  logic [QTY_W-1:0]  pub_price_q, pub_rate_q;
  logic [PCT_W-1:0]  pub_pchg_q, pub_rchg_q;

  logic              out_valid_q;
  logic [143:0]      out_data_q;
  logic [1:0]        out_user_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Input fields
  logic [TIME_W-1:0] in_now;
  logic [QTY_W-1:0]  in_price, in_rate;
  assign in_now   = s_axis_tdata_i[39:0];
  assign in_price = s_axis_tdata_i[87:40];
  assign in_rate  = s_axis_tdata_i[135:88];

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Push decision and addresses
  logic              full, do_push;
  logic [TIME_W-1:0] since_last;
  logic [SLOT_AW:0]  wsum, rsum;
  logic [SLOT_AW-1:0] waddr, raddr, head_inc;

  assign full       = (count_q == SLOTS_C);
  assign since_last = in_now - last_time_q;
  assign do_push    = (count_q == '0) ||
                      ((in_now >= last_time_q) && (since_last >= {20'd0, step_q}));
  assign wsum  = {1'b0, head_q} + {1'b0, count_q[SLOT_AW-1:0]};
  assign waddr = (wsum >= SLOTS_X) ? SLOT_AW'(wsum - SLOTS_X) : wsum[SLOT_AW-1:0];
  assign rsum  = {1'b0, head_q} + {1'b0, idx_q[SLOT_AW-1:0]};
  assign raddr = (rsum >= SLOTS_X) ? SLOT_AW'(rsum - SLOTS_X) : rsum[SLOT_AW-1:0];
  assign head_inc = (head_q == SLOT_AW'(SLOTS - 1)) ? '0 : head_q + 1'b1;

  // Scan compare
  logic [TIME_W-1:0] e_time, age, tgt_dist;
  logic [QTY_W-1:0]  e_price, e_rate;
  logic              in_win, better, last_idx;
  assign e_time  = rdata_q[TIME_W-1:0];
  assign e_price = rdata_q[TIME_W +: QTY_W];
  assign e_rate  = rdata_q[TIME_W + QTY_W +: QTY_W];
  assign age     = now_q - e_time;
  assign in_win  = (e_time <= now_q) && (age >= {20'd0, wlow_q}) && (age <= {20'd0, whigh_q});
  assign tgt_dist = (age > {20'd0, target_q}) ? age - {20'd0, target_q}
                                              : {20'd0, target_q} - age;
  assign better  = in_win && (!found_q || (tgt_dist < best_dist_q));
  assign last_idx = (idx_q + 1'b1 == count_q);

  // Divider setup and step
  logic [QTY_W-1:0] dbase, dnew, dmag;
  logic [63:0]      mag_x, num_init;
  logic [QTY_W:0]   rem_sh;
  logic             rem_ge;
  assign dbase    = divsel_q ? brate_q : bprice_q;
  assign dnew     = divsel_q ? rate_q : price_q;
  assign dmag     = (dnew < dbase) ? dbase - dnew : dnew - dbase;
  assign mag_x    = {16'd0, dmag};
  // (mag * 25) << 10 == mag * 25600, plus half the base for rounding
  assign num_init = (((mag_x << 4) + (mag_x << 3) + mag_x) << 10) + {17'd0, dbase[QTY_W-1:1]};
  assign rem_sh   = {rem_q[QTY_W-1:0], num_q[63]};
  assign rem_ge   = (rem_sh >= {1'b0, dbase});

  logic [PCT_W-1:0] sat_pct;
  always_comb begin
    if (neg_q) begin
      sat_pct = (num_q > 64'd8388608) ? PCT_NEG_MIN : (~num_q[PCT_W-1:0]) + 1'b1;
    end else begin
      sat_pct = (num_q > 64'd8388607) ? PCT_POS_MAX : num_q[PCT_W-1:0];
    end
  end

  // Snapshot memory
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_price != '0) && (in_rate != '0) && (in_now >= min_time_q) && do_push) begin
      mem[full ? head_q : waddr] <= {in_rate, in_price, in_now};
    end
    if (state_q == ST_RD) begin
      rdata_q <= mem[raddr];
    end
  end

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_time_q <= MIN_VALID_TIME_RST;
      step_q     <= STEP_SECONDS_RST;
      wlow_q     <= WINDOW_LOW_RST;
      whigh_q    <= WINDOW_HIGH_RST;
      target_q   <= TARGET_AGE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_VALID_TIME: min_time_q <= cfg_data_i;
        CFG_STEP_SECONDS:   step_q     <= cfg_data_i[SEC_W-1:0];
        CFG_WINDOW_LOW:     wlow_q     <= cfg_data_i[SEC_W-1:0];
        CFG_WINDOW_HIGH:    whigh_q    <= cfg_data_i[SEC_W-1:0];
        CFG_TARGET_AGE:     target_q   <= cfg_data_i[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      last_time_q <= '0;
      idx_q       <= '0;
      now_q       <= '0;
      price_q     <= '0;
      rate_q      <= '0;
      found_q     <= 1'b0;
      best_dist_q <= '0;
      bprice_q    <= '0;
      brate_q     <= '0;
      divsel_q    <= 1'b0;
      neg_q       <= 1'b0;
      num_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      pchg_q      <= '0;
      pub_valid_q <= 1'b0;
      pub_trend_q <= 1'b0;
      pub_price_q <= '0;
      pub_rate_q  <= '0;
      pub_pchg_q  <= '0;
      pub_rchg_q  <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != ST_PUB)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            now_q   <= in_now;
            price_q <= in_price;
            rate_q  <= in_rate;
            if ((in_price == '0) || (in_rate == '0)) begin
              state_q <= ST_PUB;
            end else if (in_now < min_time_q) begin
              pub_valid_q <= 1'b1;
              pub_trend_q <= 1'b0;
              pub_price_q <= in_price;
              pub_rate_q  <= in_rate;
              pub_pchg_q  <= '0;
              pub_rchg_q  <= '0;
              state_q     <= ST_PUB;
            end else begin
              if (do_push) begin
                last_time_q <= in_now;
                if (full) begin
                  head_q <= head_inc;
                end else begin
                  count_q <= count_q + 1'b1;
                end
              end
              idx_q   <= '0;
              found_q <= 1'b0;
              state_q <= ST_RD;
            end
          end
        end
        ST_RD: state_q <= ST_EV;
        ST_EV: begin
          if (better) begin
            found_q     <= 1'b1;
            best_dist_q <= tgt_dist;
            bprice_q    <= e_price;
            brate_q     <= e_rate;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= last_idx ? ST_CHK : ST_RD;
        end
        ST_CHK: begin
          if (found_q && (bprice_q != '0) && (brate_q != '0)) begin
            divsel_q <= 1'b0;
            state_q  <= ST_DSET;
          end else begin
            pub_valid_q <= 1'b1;
            pub_trend_q <= 1'b0;
            pub_price_q <= price_q;
            pub_rate_q  <= rate_q;
            pub_pchg_q  <= '0;
            pub_rchg_q  <= '0;
            state_q     <= ST_PUB;
          end
        end
        ST_DSET: begin
          num_q   <= num_init;
          rem_q   <= '0;
          neg_q   <= (dnew < dbase);
          dcnt_q  <= 6'd63;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= rem_ge ? rem_sh - {1'b0, dbase} : rem_sh;
          num_q  <= {num_q[62:0], rem_ge};
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == '0) begin
            state_q <= ST_DEND;
          end
        end
        ST_DEND: begin
          if (!divsel_q) begin
            pchg_q   <= sat_pct;
            divsel_q <= 1'b1;
            state_q  <= ST_DSET;
          end else begin
            pub_valid_q <= 1'b1;
            pub_trend_q <= 1'b1;
            pub_price_q <= price_q;
            pub_rate_q  <= rate_q;
            pub_pchg_q  <= pchg_q;
            pub_rchg_q  <= sat_pct;
            state_q     <= ST_PUB;
          end
        end
        ST_PUB: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {pub_rchg_q, pub_pchg_q, pub_rate_q, pub_price_q};
            out_user_q  <= {pub_trend_q, pub_valid_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOTS_C) else $error("stored count above slot count");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= SLOT_AW'(SLOTS - 1)) && ((head_q == '0) || full))
    else $error("head moved while store not full");

  a_trend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_user_q[1] || out_user_q[0]))
    else $error("trend flagged without valid data");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE)) else $error("accepted item not processed");

endmodule
`default_nettype wire
